// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// aes_pkg
// Types, constants and byte-level round functions for the AES pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

    localparam int RK_DEPTH   = 60;
    localparam int MAX_ROUNDS = 14;
    localparam int NUM_CELLS  = MAX_ROUNDS + 1;

    localparam logic [7:0] GF_POLY = 8'h1b;
    localparam logic [7:0] GF_TOP  = 8'h80;
    localparam logic [3:0] NR_BASE = 4'd6;

    // key size codes
    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;
    localparam logic [1:0] KS_256 = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_KEY_SIZE = 3'd0;
    localparam logic [2:0] REG_KEY_0    = 3'd1;
    localparam logic [2:0] REG_KEY_1    = 3'd2;
    localparam logic [2:0] REG_KEY_2    = 3'd3;
    localparam logic [2:0] REG_KEY_3    = 3'd4;

    // commands
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    // per-transaction control carried down the cell chain
    typedef struct packed {
        logic       command;
        logic [1:0] key_size;
    } aes_ctl_t;

    localparam logic [2047:0] SBOX_TBL = {
        128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

    localparam logic [2047:0] INV_SBOX_TBL = {
        128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

    function automatic logic [7:0] sbox(input logic [7:0] x);
        return SBOX_TBL[{~x, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        return INV_SBOX_TBL[{~x, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return (a & GF_TOP) != 8'h00 ? ({a[6:0], 1'b0} ^ GF_POLY) : {a[6:0], 1'b0};
    endfunction

    // rounds for a key size code; code three saturates to 256 bits
    function automatic logic [3:0] num_rounds(input logic [1:0] ks);
        logic [1:0] k;
        k = (ks == 2'd3) ? KS_256 : ks;
        return NR_BASE + 4'd4 + {1'b0, k, 1'b0};
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // byte i of the state sits at [127-8i -: 8]
    function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        for (int i = 0; i < 16; i++) begin
            r[8*i +: 8] = inv ? inv_sbox(s[8*i +: 8]) : sbox(s[8*i +: 8]);
        end
        return r;
    endfunction

    function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        int src;
        for (int c = 0; c < 4; c++) begin
            for (int w = 0; w < 4; w++) begin
                src = inv ? ((c + 4 - w) % 4) : ((c + w) % 4);
                r[127 - 8*(w + 4*c) -: 8] = s[127 - 8*(w + 4*src) -: 8];
            end
        end
        return r;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] r;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[127 - 32*c -: 8];
            a1 = s[119 - 32*c -: 8];
            a2 = s[111 - 32*c -: 8];
            a3 = s[103 - 32*c -: 8];
            r[127 - 32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            r[119 - 32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            r[111 - 32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            r[103 - 32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return r;
    endfunction

    function automatic logic [127:0] inv_mix_columns(input logic [127:0] s);
        logic [127:0] r;
        logic [7:0] a [4];
        logic [7:0] m9 [4];
        logic [7:0] m11 [4];
        logic [7:0] m13 [4];
        logic [7:0] m14 [4];
        logic [7:0] x2, x4, x8;
        for (int c = 0; c < 4; c++) begin
            for (int t = 0; t < 4; t++) begin
                a[t]   = s[127 - 8*(t + 4*c) -: 8];
                x2     = xtime(a[t]);
                x4     = xtime(x2);
                x8     = xtime(x4);
                m9[t]  = x8 ^ a[t];
                m11[t] = x8 ^ x2 ^ a[t];
                m13[t] = x8 ^ x4 ^ a[t];
                m14[t] = x8 ^ x4 ^ x2;
            end
            r[127 - 32*c -: 8] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
            r[119 - 32*c -: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
            r[111 - 32*c -: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
            r[103 - 32*c -: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/aes_key_expand.sv =====
// ----------------------------------------------------------------------------
// aes_key_expand
// Key registers and iterative key schedule, one round-key word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_key_expand
    import aes_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    output logic [1:0]       key_size,
    output logic             keys_ready,
    output logic [31:0]      round_keys [RK_DEPTH]
);

    logic [1:0]  ks_reg;
    logic [63:0] key_reg [4];
    logic        start_reg;
    logic        busy_reg;
    logic [5:0]  idx_reg;
    logic [2:0]  phase_reg;
    logic [7:0]  rcon_reg;
    logic [31:0] win_reg [8];
    logic [31:0] rk_reg [RK_DEPTH];

    logic [1:0]  ks_sat;
    logic [3:0]  nk;
    logic [5:0]  total;
    logic [31:0] kw [8];
    logic [31:0] far_word;
    logic [31:0] temp;
    logic [31:0] new_word;
    logic        last_phase;

    assign ks_sat     = (ks_reg == 2'd3) ? KS_256 : ks_reg;
    assign nk         = 4'd4 + {1'b0, ks_sat, 1'b0};
    assign total      = {num_rounds(ks_reg) + 4'd1, 2'b00};
    assign last_phase = ({1'b0, phase_reg} == nk - 4'd1);

    // key words in schedule order
    always_comb begin
        for (int m = 0; m < 8; m++) begin
            kw[m] = m[0] ? key_reg[m/2][31:0] : key_reg[m/2][63:32];
        end
    end

    // word Nk back in the window
    always_comb begin
        case (ks_sat)
            KS_128:  far_word = win_reg[3];
            KS_192:  far_word = win_reg[5];
            default: far_word = win_reg[7];
        endcase
    end

    always_comb begin
        temp = win_reg[0];
        if (phase_reg == 3'd0) begin
            temp = sub_word({win_reg[0][23:0], win_reg[0][31:24]}) ^ {rcon_reg, 24'h0};
        end else if (ks_sat == KS_256 && phase_reg == 3'd4) begin
            temp = sub_word(win_reg[0]);
        end
        new_word = far_word ^ temp;
    end

    // configuration writes; any valid write restarts expansion
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ks_reg    <= KS_128;
            key_reg   <= '{default: '0};
            start_reg <= 1'b1;
        end else begin
            start_reg <= 1'b0;
            if (cfg_we && cfg_index == REG_KEY_SIZE) begin
                ks_reg    <= cfg_data[1:0];
                start_reg <= 1'b1;
            end else if (cfg_we && cfg_index >= REG_KEY_0 && cfg_index <= REG_KEY_3) begin
                key_reg[2'(cfg_index - REG_KEY_0)] <= cfg_data;
                start_reg <= 1'b1;
            end
        end
    end

    // schedule sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            phase_reg <= '0;
            rcon_reg  <= 8'h01;
        end else if (start_reg) begin
            busy_reg  <= 1'b1;
            idx_reg   <= {2'b00, nk};
            phase_reg <= '0;
            rcon_reg  <= 8'h01;
        end else if (busy_reg) begin
            idx_reg   <= idx_reg + 6'd1;
            phase_reg <= last_phase ? 3'd0 : phase_reg + 3'd1;
            if (phase_reg == 3'd0) begin
                rcon_reg <= xtime(rcon_reg);
            end
            if (idx_reg == total - 6'd1) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // window and round-key store
    always_ff @(posedge aclk) begin
        if (start_reg) begin
            for (int m = 0; m < 8; m++) begin
                rk_reg[m] <= kw[m];
            end
            for (int m = 0; m < 8; m++) begin
                win_reg[m] <= kw[3'(nk - 4'd1 - 4'(m))];
            end
        end else if (busy_reg) begin
            rk_reg[idx_reg] <= new_word;
            win_reg[0]      <= new_word;
            for (int m = 1; m < 8; m++) begin
                win_reg[m] <= win_reg[m-1];
            end
        end
    end

    assign key_size   = ks_reg;
    assign keys_ready = !busy_reg && !start_reg;
    assign round_keys = rk_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/aes_round_cell.sv =====
// ----------------------------------------------------------------------------
// aes_round_cell
// One pipeline cell: applies round ROUND of encryption or decryption.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_round_cell
    import aes_pkg::*;
#(
    parameter int ROUND = 0
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire aes_ctl_t     in_ctl,
    input  wire logic [127:0] in_state,
    input  wire logic [127:0] key_enc,
    input  wire logic [127:0] key_dec [3],
    output logic              out_valid,
    input  wire logic         out_ready,
    output aes_ctl_t          out_ctl,
    output logic [127:0]      out_state
);

    localparam logic [3:0] RND = 4'(ROUND);

    logic         valid_reg;
    aes_ctl_t     ctl_reg;
    logic [127:0] state_reg;

    logic [3:0]   nr;
    logic         active;
    logic         last;
    logic [127:0] key;
    logic [127:0] enc_sr;
    logic [127:0] enc_out;
    logic [127:0] dec_ak;
    logic [127:0] dec_out;
    logic [127:0] state_next;

    assign nr     = num_rounds(in_ctl.key_size);
    assign active = (RND <= nr);
    assign last   = (RND == nr);

    // decrypt key index counts down from Nr
    always_comb begin
        case (nr)
            4'd10:   key = key_dec[0];
            4'd12:   key = key_dec[1];
            default: key = key_dec[2];
        endcase
        if (in_ctl.command == CMD_ENCRYPT) begin
            key = key_enc;
        end
    end

    // round datapath
    always_comb begin
        enc_sr  = shift_rows(sub_bytes(in_state, 1'b0), 1'b0);
        enc_out = (last ? enc_sr : mix_columns(enc_sr)) ^ key;
        dec_ak  = sub_bytes(shift_rows(in_state, 1'b1), 1'b1) ^ key;
        dec_out = last ? dec_ak : inv_mix_columns(dec_ak);
        if (ROUND == 0) begin
            state_next = in_state ^ key;
        end else if (!active) begin
            state_next = in_state;
        end else if (in_ctl.command == CMD_ENCRYPT) begin
            state_next = enc_out;
        end else begin
            state_next = dec_out;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            ctl_reg   <= in_ctl;
            state_reg <= state_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_state = state_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/aes_block_cipher.sv =====
// ----------------------------------------------------------------------------
// aes_block_cipher
// AES-128/192/256 encrypt and decrypt as a chain of fifteen round cells.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    s_command, s_block_hi, s_block_lo
//   m_       out        m_valid/m_ready    m_result_hi, m_result_lo
//   cfg_     in         cfg_we             cfg_index, cfg_data
//
// One transaction per cycle when not stalled by m_ready or the key schedule; one register per cell.
// Each cell has its own valid and ready, so bubbles close up under a stall.
// After reset and after every key size or key register write, the key
// schedule rebuilds one word per cycle; s_ready stays low meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_block_cipher
    import aes_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_command,
    input  wire logic [63:0] s_block_hi,
    input  wire logic [63:0] s_block_lo,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_result_hi,
    output logic [63:0]      m_result_lo
);

    `include "assert_macros.svh"

    logic [1:0]   key_size;
    logic         keys_ready;
    logic [31:0]  round_keys [RK_DEPTH];

    logic         pv [NUM_CELLS+1];
    logic         pr [NUM_CELLS+1];
    aes_ctl_t     pc [NUM_CELLS+1];
    logic [127:0] ps [NUM_CELLS+1];

    aes_key_expand u_key_expand (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .key_size   (key_size),
        .keys_ready (keys_ready),
        .round_keys (round_keys)
    );

    // chain head
    assign pv[0]         = s_valid && keys_ready;
    assign pc[0].command = s_command;
    assign pc[0].key_size = key_size;
    assign ps[0]         = {s_block_hi, s_block_lo};
    assign s_ready       = pr[0] && keys_ready;

    // round cells
    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        localparam int D10 = (k <= 10) ? 10 - k : 0;
        localparam int D12 = (k <= 12) ? 12 - k : 0;
        localparam int D14 = 14 - k;

        logic [127:0] key_enc;
        logic [127:0] key_dec [3];

        assign key_enc = {round_keys[4*k], round_keys[4*k+1],
                          round_keys[4*k+2], round_keys[4*k+3]};
        assign key_dec[0] = {round_keys[4*D10], round_keys[4*D10+1],
                             round_keys[4*D10+2], round_keys[4*D10+3]};
        assign key_dec[1] = {round_keys[4*D12], round_keys[4*D12+1],
                             round_keys[4*D12+2], round_keys[4*D12+3]};
        assign key_dec[2] = {round_keys[4*D14], round_keys[4*D14+1],
                             round_keys[4*D14+2], round_keys[4*D14+3]};

        aes_round_cell #(
            .ROUND (k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (pv[k]),
            .in_ready  (pr[k]),
            .in_ctl    (pc[k]),
            .in_state  (ps[k]),
            .key_enc   (key_enc),
            .key_dec   (key_dec),
            .out_valid (pv[k+1]),
            .out_ready (pr[k+1]),
            .out_ctl   (pc[k+1]),
            .out_state (ps[k+1])
        );
    end

    // chain tail
    assign pr[NUM_CELLS] = m_ready;
    assign m_valid       = pv[NUM_CELLS];
    assign m_result_hi   = ps[NUM_CELLS][127:64];
    assign m_result_lo   = ps[NUM_CELLS][63:0];

    // no transaction enters while round keys are being rebuilt
    `ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, s_ready, keys_ready)
    // a key write stops input on the next cycle
    `ASSERT_NEXT(a_cfg_blocks, aclk, aresetn,
        cfg_we && cfg_index <= REG_KEY_3, !s_ready)
    // a stalled first cell keeps its transaction
    `ASSERT_NEXT(a_head_holds, aclk, aresetn, pv[1] && !pr[1], pv[1])

endmodule

`default_nettype wire

// ===== sim/tb_aes_block_cipher.sv =====
// ----------------------------------------------------------------------------
// tb_aes_block_cipher
// Self-checking bench for the AES block cipher: queued random and directed
// blocks under several key settings and handshake idling phases, checked
// against an in-bench cipher model with its own key schedule.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_aes_block_cipher;
    import aes_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1500000;
    // index past the register list
    localparam logic [2:0] REG_UNUSED = 3'd5;

    typedef struct {
        logic        command;
        logic [63:0] hi;
        logic [63:0] lo;
    } blk_t;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
    } res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_command = 1'b0;
    logic [63:0] s_block_hi = '0;
    logic [63:0] s_block_lo = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_result_hi;
    logic [63:0] m_result_lo;

    aes_block_cipher dut (.*);

    always #6 aclk = ~aclk;

    // model configuration and round keys
    logic [1:0]  cur_key_size;
    logic [63:0] cur_key [4];
    logic [31:0] rkw [60];

    blk_t pending_blocks[$];
    res_t expected_results[$];
    int   error_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_off = 0;
    bit   send_hold = 1'b0;
    longint cycles = 0;

    // GF(2^8) helpers and byte substitution, computed algebraically
    function automatic logic [7:0] gf_x2(input logic [7:0] a);
        return a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= a;
            a = gf_x2(a);
        end
        return acc;
    endfunction

    function automatic logic [7:0] gf_inverse(input logic [7:0] x);
        logic [7:0] r, base;
        r = 8'h01;
        base = x;
        for (int e = 0; e < 8; e++) begin
            if (e != 0) r = gf_mul(r, base);
            base = gf_mul(base, base);
        end
        return r;
    endfunction

    function automatic logic [7:0] rol8(input logic [7:0] v, input int n);
        return (v << n) | (v >> (8 - n));
    endfunction

    function automatic logic [7:0] fwd_sub(input logic [7:0] x);
        logic [7:0] b;
        b = gf_inverse(x);
        return b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ 8'h63;
    endfunction

    function automatic logic [7:0] rev_sub(input logic [7:0] y);
        return gf_inverse(rol8(y, 1) ^ rol8(y, 3) ^ rol8(y, 6) ^ 8'h05);
    endfunction

    function automatic int key_word_count();
        return (cur_key_size == KS_128) ? 4 : (cur_key_size == KS_192) ? 6 : 8;
    endfunction

    task automatic build_schedule();
        int nk, total;
        logic [31:0] t;
        logic [7:0] rc;
        nk = key_word_count();
        total = 4 * (7 + nk);
        rc = 8'h01;
        for (int i = 0; i < nk; i++)
            rkw[i] = i[0] ? cur_key[i/2][31:0] : cur_key[i/2][63:32];
        for (int i = nk; i < total && i < 60; i++) begin
            t = rkw[i-1];
            if (i % nk == 0) begin
                t = {t[23:0], t[31:24]};
                t = {fwd_sub(t[31:24]), fwd_sub(t[23:16]), fwd_sub(t[15:8]),
                     fwd_sub(t[7:0])} ^ {rc, 24'h0};
                rc = gf_x2(rc);
            end else if (nk > 6 && i % nk == 4) begin
                t = {fwd_sub(t[31:24]), fwd_sub(t[23:16]), fwd_sub(t[15:8]),
                     fwd_sub(t[7:0])};
            end
            rkw[i] = rkw[i-nk] ^ t;
        end
    endtask

    // state as 16 bytes, byte i = row i%4, column i/4
    function automatic res_t cipher_block(input blk_t b);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [7:0] co [4];
        int nr, rnd;
        res_t r;
        nr = 6 + key_word_count();
        for (int i = 0; i < 8; i++) begin
            s[i] = b.hi[63-8*i -: 8];
            s[i+8] = b.lo[63-8*i -: 8];
        end
        if (b.command == CMD_ENCRYPT) begin
            co = '{8'd2, 8'd3, 8'd1, 8'd1};
        end else begin
            co = '{8'd14, 8'd11, 8'd13, 8'd9};
        end
        for (int step = 0; step <= nr; step++) begin
            rnd = (b.command == CMD_ENCRYPT) ? step : nr - step;
            if (step > 0) begin
                // substitution and row shift, direction by command
                t = s;
                for (int c = 0; c < 4; c++)
                    for (int w = 0; w < 4; w++)
                        s[w+4*c] = t[w + 4*((b.command == CMD_ENCRYPT) ?
                                   ((c+w)%4) : ((c+4-w)%4))];
                for (int i = 0; i < 16; i++)
                    s[i] = (b.command == CMD_ENCRYPT) ? fwd_sub(s[i]) : rev_sub(s[i]);
                if (b.command == CMD_ENCRYPT && step < nr) begin
                    t = s;
                    for (int c = 0; c < 4; c++)
                        for (int w = 0; w < 4; w++) begin
                            s[4*c+w] = 8'h00;
                            for (int k = 0; k < 4; k++)
                                s[4*c+w] ^= gf_mul(t[4*c+k], co[(k+4-w)%4]);
                        end
                end
            end
            for (int i = 0; i < 16; i++)
                s[i] ^= rkw[4*rnd + i/4][8*(3-i%4) +: 8];
            // decrypt mixes after the key add, except after the first and last ones
            if (b.command == CMD_DECRYPT && step > 0 && step < nr) begin
                t = s;
                for (int c = 0; c < 4; c++)
                    for (int w = 0; w < 4; w++) begin
                        s[4*c+w] = 8'h00;
                        for (int k = 0; k < 4; k++)
                            s[4*c+w] ^= gf_mul(t[4*c+k], co[(k+4-w)%4]);
                    end
            end
        end
        for (int i = 0; i < 8; i++) begin
            r.hi[63-8*i -: 8] = s[i];
            r.lo[63-8*i -: 8] = s[i+8];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    // register write, mirrored in the model
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_KEY_SIZE) cur_key_size = val[1:0];
        else if (idx <= REG_KEY_3) cur_key[idx - REG_KEY_0] = val;
        if (idx == REG_KEY_SIZE && val[1:0] == 2'd3) cur_key_size = KS_256;
        build_schedule();
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // append one block to the pending queue
    task automatic enqueue_block(input logic cmd, input logic [63:0] hi,
                                 input logic [63:0] lo);
        blk_t b;
        b.command = cmd;
        b.hi = hi;
        b.lo = lo;
        pending_blocks.insert(pending_blocks.size(), b);
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++) begin
            enqueue_block(1'($urandom_range(1, 0)), rand64(), rand64());
        end
    endtask

    task automatic drain();
        while (pending_blocks.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) expected_results.insert(expected_results.size(),
                cipher_block('{s_command, s_block_hi, s_block_lo}));
            if (pending_blocks.size() != 0 && !send_hold &&
                $urandom_range(99, 0) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_command <= pending_blocks[0].command;
                s_block_hi <= pending_blocks[0].hi;
                s_block_lo <= pending_blocks[0].lo;
                void'(pending_blocks.pop_front());
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge aclk) begin
        res_t want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_aes_block_cipher: done, errors");
            $finish;
        end else if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", m_result_hi, 64'h0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_result_hi !== want.hi) report_mismatch("hi", m_result_hi, want.hi);
                    if (m_result_lo !== want.lo) report_mismatch("lo", m_result_lo, want.lo);
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
            end
        end
    end

    initial begin
        cur_key_size = KS_128;
        for (int i = 0; i < 4; i++) cur_key[i] = '0;
        for (int i = 0; i < 60; i++) rkw[i] = '0;
        build_schedule();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset key, field extremes, both commands
        for (int c = 0; c < 2; c++) begin
            enqueue_block(c[0], 64'h0, 64'h0);
            enqueue_block(c[0], '1, '1);
            enqueue_block(c[0], 64'h00112233_44556677, 64'h8899aabb_ccddeeff);
            enqueue_block(c[0], 64'h80000000_00000000, 64'h1);
        end
        drain();

        // standard 256-bit test key, run under each key size code
        write_reg(REG_KEY_0, 64'h00010203_04050607);
        write_reg(REG_KEY_1, 64'h08090a0b_0c0d0e0f);
        write_reg(REG_KEY_2, 64'h10111213_14151617);
        write_reg(REG_KEY_3, 64'h18191a1b_1c1d1e1f);
        write_reg(REG_UNUSED, rand64());  // no effect
        for (int ks = 0; ks < 4; ks++) begin
            write_reg(REG_KEY_SIZE, 64'(ks));
            enqueue_block(CMD_ENCRYPT, 64'h00112233_44556677, 64'h8899aabb_ccddeeff);
            enqueue_block(CMD_DECRYPT, '1, 64'h0);
            drain();
        end

        // random phases over key settings and idling mixes
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_KEY_SIZE, 64'(ph % 3));
            for (int k = 0; k < 4; k++)
                write_reg(3'(REG_KEY_0 + k), (ph == 1) ? '1 : (ph == 2) ? '0 : rand64());
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            queue_random(70);
            if (ph == 0) begin
                // long receiver hold-off while the sender keeps offering
                @(posedge aclk);
                hold_off <= 300;
            end
            while (pending_blocks.size() > 35) @(posedge aclk);
            if (ph == 3) begin
                // sender waits until every result is back
                send_hold = 1'b1;
                while (s_valid || expected_results.size() != 0) @(posedge aclk);
                send_hold = 1'b0;
            end
            queue_random(70);
            drain();
        end

        if (error_count == 0) begin
            $display("tb_aes_block_cipher: done, clean");
        end else begin
            $display("tb_aes_block_cipher: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/aes_pkg.sv
hw/rtl/aes_key_expand.sv
hw/rtl/aes_round_cell.sv
hw/rtl/aes_block_cipher.sv
sim/tb_aes_block_cipher.sv
